@@ src/lsf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants for the learning switch forwarder.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int PORT_W    = 2;
  localparam int ADDR_W    = 48;
  localparam int TAG_W     = 16;
  localparam int MASK_W    = 4;
  localparam int NUM_PORTS = 4;

  // egress bits for ports that do not exist are always cleared
  localparam logic [MASK_W-1:0] VALID_PORT_MASK =
    (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_PORTS) - 1);

  localparam logic [MASK_W-1:0] FLOOD_MASK_RESET = {MASK_W{1'b1}};

  typedef struct packed {
    logic [PORT_W-1:0] ingress_port;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [TAG_W-1:0]  frame_tag;
    logic              self_addr;   // source equals destination
  } hdr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } entry_t;

endpackage

@@ src/lsf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_front
// Accepts frame headers, tags source-equals-destination, and holds them in a
// two-entry queue ahead of the table scan.
// ----------------------------------------------------------------------------
module lsf_front
  import lsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PORT_W-1:0] ingress_port,
  input  logic [ADDR_W-1:0] src_addr,
  input  logic [ADDR_W-1:0] dst_addr,
  input  logic [TAG_W-1:0]  frame_tag,
  output logic              hdr_valid,
  input  logic              hdr_ready,
  output hdr_t              hdr
);

  hdr_t       q [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  hdr_t       hdr_in;

  assign in_ready  = (fill != 2'd2);
  assign hdr_valid = (fill != 2'd0);
  assign hdr       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = hdr_valid && hdr_ready;

  always_comb begin
    hdr_in.ingress_port = ingress_port;
    hdr_in.src_addr     = src_addr;
    hdr_in.dst_addr     = dst_addr;
    hdr_in.frame_tag    = frame_tag;
    hdr_in.self_addr    = (src_addr == dst_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= hdr_in;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'd2) else $error("front queue overfilled");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fill == $past(fill) + 2'd1) else $error("fill count lost a push");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 || fill == 2'd2) |-> wr_ptr == rd_ptr) else $error("queue pointers out of step");

endmodule

@@ src/lsf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_back
// Scans the address table one entry a cycle for source and destination,
// learns a new source, and builds the forwarding result in an output register.
// ----------------------------------------------------------------------------
module lsf_back
  import lsf_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              flood_port_mask_we,
  input  logic [MASK_W-1:0] flood_port_mask,
  input  logic              hdr_valid,
  output logic              hdr_ready,
  input  hdr_t              hdr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] egress_mask,
  output logic              flooded,
  output logic              learned,
  output logic              table_full,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;

  logic [1:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     idx, idx_next;
  logic              rd_pend, rd_pend_next;
  logic              src_hit, src_hit_next;
  logic              dst_hit, dst_hit_next;
  logic [PORT_W-1:0] dst_port, dst_port_next;
  logic [MASK_W-1:0] flood_mask;
  hdr_t              cur;

  entry_t            mem [0:TABLE_DEPTH-1];
  entry_t            rd_data;
  logic              rd_en;
  logic              wr_en;

  logic              out_load;
  logic              learn_now;
  logic              full_now;
  logic              hit_now;
  logic [PORT_W-1:0] port_now;
  logic [MASK_W-1:0] egress_now;

  assign hdr_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    rd_pend_next  = rd_pend;
    src_hit_next  = src_hit;
    dst_hit_next  = dst_hit;
    dst_port_next = dst_port;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    out_load      = 1'b0;
    learn_now     = !src_hit && (count != DEPTH_C);
    full_now      = !src_hit && (count == DEPTH_C);
    // a frame sent to the address it has just taught goes back out its own port
    hit_now       = dst_hit || (learn_now && cur.self_addr);
    port_now      = dst_hit ? dst_port : cur.ingress_port;
    egress_now    = (hit_now ? (MASK_W'(1) << port_now) : flood_mask) & VALID_PORT_MASK;
    unique case (state)
      ST_IDLE: begin
        if (hdr_valid) begin
          idx_next     = '0;
          rd_pend_next = 1'b0;
          src_hit_next = 1'b0;
          dst_hit_next = 1'b0;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_pend) begin
          if (rd_data.addr == cur.src_addr) src_hit_next = 1'b1;
          if (rd_data.addr == cur.dst_addr && !dst_hit) begin
            dst_hit_next  = 1'b1;
            dst_port_next = rd_data.port;
          end
        end
        if (idx != count) begin
          rd_en        = 1'b1;
          idx_next     = idx + CW'(1);
          rd_pend_next = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          if (!rd_pend) state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          wr_en      = learn_now;
          if (learn_now) count_next = count + CW'(1);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      out_valid  <= 1'b0;
      flood_mask <= FLOOD_MASK_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (flood_port_mask_we) flood_mask <= flood_port_mask;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    rd_pend  <= rd_pend_next;
    src_hit  <= src_hit_next;
    dst_hit  <= dst_hit_next;
    dst_port <= dst_port_next;
    if (state == ST_IDLE && hdr_valid) cur <= hdr;
    if (out_load) begin
      egress_mask <= egress_now;
      flooded     <= !hit_now;
      learned     <= learn_now;
      table_full  <= full_now;
      out_tag     <= cur.frame_tag;
    end
  end

  // address table: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IW-1:0]].addr <= cur.src_addr;
      mem[count[IW-1:0]].port <= cur.ingress_port;
    end
    if (rd_en) rd_data <= mem[idx[IW-1:0]];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C) else $error("entry count beyond table depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RESOLVE) |=> count == $past(count)) else $error("table grew outside resolve");

  a_learn_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(learned && table_full)) else $error("learned and full together");

  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !flooded) |-> $onehot0(egress_mask)) else $error("forwarded to several ports");

endmodule

@@ src/learning_switch_forwarder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learning_switch_forwarder
// Learning bridge: source address learning and destination lookup per header.
// ----------------------------------------------------------------------------
// The back end walks the address table one entry per cycle through a single
// memory read port, checking source and destination in the same pass, then
// learns the source and loads the result in its resolve state. A two-entry
// queue takes new headers while a scan runs, and the output register holds a
// finished result until it is taken. No clearing pass is needed after reset.
module learning_switch_forwarder
  import lsf_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              flood_port_mask_we,
  input  logic [MASK_W-1:0] flood_port_mask,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PORT_W-1:0] ingress_port,
  input  logic [ADDR_W-1:0] src_addr,
  input  logic [ADDR_W-1:0] dst_addr,
  input  logic [TAG_W-1:0]  frame_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] egress_mask,
  output logic              flooded,
  output logic              learned,
  output logic              table_full,
  output logic [TAG_W-1:0]  out_tag
);

  logic hdr_valid;
  logic hdr_ready;
  hdr_t hdr;

  lsf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ingress_port (ingress_port),
    .src_addr     (src_addr),
    .dst_addr     (dst_addr),
    .frame_tag    (frame_tag),
    .hdr_valid    (hdr_valid),
    .hdr_ready    (hdr_ready),
    .hdr          (hdr)
  );

  lsf_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .flood_port_mask_we (flood_port_mask_we),
    .flood_port_mask    (flood_port_mask),
    .hdr_valid          (hdr_valid),
    .hdr_ready          (hdr_ready),
    .hdr                (hdr),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .egress_mask        (egress_mask),
    .flooded            (flooded),
    .learned            (learned),
    .table_full         (table_full),
    .out_tag            (out_tag)
  );

endmodule

@@ tb/learning_switch_forwarder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learning_switch_forwarder_test
// Self-checking bench for the learning bridge forwarder.
// Frame headers go in over a valid/ready channel. A local copy of the address
// table predicts the egress mask and the flood, learn and table full flags of
// every header. Each result is then checked in order against that prediction.
// The flood mask changes between phases while the block is idle. Sender gaps
// and receiver stalls vary from phase to phase, and the last phase fills the
// address table.
// ----------------------------------------------------------------------------
import lsf_pkg::*;

typedef struct packed {
  logic [MASK_W-1:0] egress;
  logic              flooded;
  logic              learned;
  logic              full;
  logic [TAG_W-1:0]  tag;
} fwd_result_t;

class forwarding_checker #(int DEPTH = 64);
  logic [ADDR_W-1:0] host_addr [DEPTH];
  logic [PORT_W-1:0] host_port [DEPTH];
  int unsigned       hosts_known;
  logic [MASK_W-1:0] flood_mask;
  fwd_result_t       due_q[$];
  int unsigned       errors, frames, n_learned, n_flooded, n_full;

  function new();
    hosts_known = 0;
    flood_mask  = FLOOD_MASK_RESET;
    errors      = 0;
    frames      = 0;
    n_learned   = 0;
    n_flooded   = 0;
    n_full      = 0;
  endfunction

  function int lookup(logic [ADDR_W-1:0] a);
    for (int i = 0; i < hosts_known; i++)
      if (host_addr[i] == a) return i;
    return -1;
  endfunction

  // source is learned before the destination lookup, so a self-addressed
  // frame hits its own new entry
  function void note_frame(logic [PORT_W-1:0] port, logic [ADDR_W-1:0] src,
                           logic [ADDR_W-1:0] dst, logic [TAG_W-1:0] tag);
    fwd_result_t r;
    int          hit;
    r.learned = 1'b0;
    r.full    = 1'b0;
    r.tag     = tag;
    if (lookup(src) < 0) begin
      if (hosts_known < DEPTH) begin
        host_addr[hosts_known] = src;
        host_port[hosts_known] = port;
        hosts_known++;
        r.learned = 1'b1;
      end else begin
        r.full = 1'b1;
      end
    end
    hit = lookup(dst);
    if (hit >= 0) begin
      r.egress  = MASK_W'(1) << host_port[hit];
      r.flooded = 1'b0;
    end else begin
      r.egress  = flood_mask;
      r.flooded = 1'b1;
    end
    r.egress &= VALID_PORT_MASK;
    due_q = {due_q, r};
  endfunction

  function void check_result(fwd_result_t got);
    fwd_result_t want;
    if (due_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result with no frame pending: egress %h tag %h",
                 $realtime, got.egress, got.tag);
      return;
    end
    want = due_q.pop_front();
    frames++;
    n_learned += want.learned;
    n_flooded += want.flooded;
    n_full    += want.full;
    if (got.egress !== want.egress || got.flooded !== want.flooded ||
        got.learned !== want.learned || got.full !== want.full ||
        got.tag !== want.tag) begin
      errors++;
      if (errors <= 10)
        $display({"%0t: mismatch on frame %0d: expected egress %h flooded %b ",
                  "learned %b full %b tag %h, got egress %h flooded %b ",
                  "learned %b full %b tag %h"}, $realtime, frames,
                 want.egress, want.flooded, want.learned, want.full, want.tag,
                 got.egress, got.flooded, got.learned, got.full, got.tag);
    end
  endfunction

  function int pending();
    return due_q.size();
  endfunction
endclass

module learning_switch_forwarder_test;

  localparam int TABLE_DEPTH     = 64;
  localparam int NUM_PHASES      = 7;
  localparam int LAST_PHASE      = NUM_PHASES - 1;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOSTS           = 48;
  localparam int STALL_LIMIT     = 4000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              flood_port_mask_we = 1'b0;
  logic [MASK_W-1:0] flood_port_mask = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PORT_W-1:0] ingress_port = '0;
  logic [ADDR_W-1:0] src_addr = '0;
  logic [ADDR_W-1:0] dst_addr = '0;
  logic [TAG_W-1:0]  frame_tag = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MASK_W-1:0] egress_mask;
  logic              flooded;
  logic              learned;
  logic              table_full;
  logic [TAG_W-1:0]  out_tag;

  forwarding_checker #(TABLE_DEPTH) sb;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                quiet_cycles = 0;
  logic [ADDR_W-1:0] hosts [HOSTS];
  logic [MASK_W-1:0] phase_mask [NUM_PHASES] = '{4'hF, 4'h0, 4'h5, 4'hA, 4'h1, 4'h8, 4'h6};

  learning_switch_forwarder #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .flood_port_mask_we(flood_port_mask_we),
    .flood_port_mask(flood_port_mask),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ingress_port(ingress_port),
    .src_addr(src_addr),
    .dst_addr(dst_addr),
    .frame_tag(frame_tag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .egress_mask(egress_mask),
    .flooded(flooded),
    .learned(learned),
    .table_full(table_full),
    .out_tag(out_tag)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // called at a clock edge; returns at the edge where the item is taken
  task automatic send_frame(input logic [PORT_W-1:0] port, input logic [ADDR_W-1:0] src,
                            input logic [ADDR_W-1:0] dst, input logic [TAG_W-1:0] tag);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid     <= 1'b1;
    ingress_port <= port;
    src_addr     <= src;
    dst_addr     <= dst;
    frame_tag    <= tag;
    do @(posedge clk); while (!in_ready);
    sb.note_frame(port, src, dst, tag);
  endtask

  task automatic write_flood_mask(input logic [MASK_W-1:0] m);
    flood_port_mask_we <= 1'b1;
    flood_port_mask    <= m;
    @(posedge clk);
    flood_port_mask_we <= 1'b0;
    sb.flood_mask = m;
  endtask

  // result side: check on each taken item, then pick the next ready level
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result('{egress: egress_mask, flooded: flooded, learned: learned,
                          full: table_full, tag: out_tag});
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int                lim, sel;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] src, dst;
    logic [TAG_W-1:0]  tag;

    sb = new();
    hosts[0] = '0;
    hosts[1] = '1;
    for (int h = 2; h < HOSTS; h++) hosts[h] = rand_addr();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: address extremes, self-addressed frame, known source moving
    // port, hits to every port, unknown destination at the reset flood mask
    send_frame(2'd0, hosts[0], hosts[1], 16'h0000);
    send_frame(2'd3, hosts[1], hosts[0], 16'hFFFF);
    send_frame(2'd1, hosts[2], hosts[2], 16'hAAAA);
    send_frame(2'd2, hosts[2], hosts[2], 16'h5555);
    send_frame(2'd2, hosts[3], hosts[1], 16'h1234);
    send_frame(2'd3, hosts[0], hosts[3], 16'h8001);
    send_frame(2'd1, hosts[1], rand_addr(), 16'h7FFE);
    send_frame(2'd0, hosts[3], hosts[0], 16'h00FF);
    in_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      while (sb.pending() != 0) @(posedge clk);
      write_flood_mask(phase_mask[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      // the host pool widens each phase; only the last phase brings fresh
      // sources, which fill the table
      lim = (p == LAST_PHASE) ? HOSTS - 1 : 11 + 6 * p;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        port = PORT_W'($urandom_range(3));
        if (p == LAST_PHASE && $urandom_range(99) < 40)
          src = rand_addr();
        else
          src = hosts[$urandom_range(lim)];
        sel = $urandom_range(99);
        if (sel < 70)
          dst = hosts[$urandom_range(lim)];
        else if (sel < 80)
          dst = src;
        else
          dst = rand_addr();
        tag = TAG_W'($urandom());
        send_frame(port, src, dst, tag);
      end
      in_valid <= 1'b0;
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("checked %0d frame headers over %0d flood masks and four idling patterns",
             sb.frames, NUM_PHASES + 1);
    $display("%0d sources learned, %0d frames flooded, %0d refused with the table full (%0d/%0d)",
             sb.n_learned, sb.n_flooded, sb.n_full, sb.hosts_known, TABLE_DEPTH);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ learning_switch_forwarder.f @@
src/lsf_pkg.sv
src/lsf_front.sv
src/lsf_back.sv
src/learning_switch_forwarder.sv
tb/learning_switch_forwarder_test.sv
